/* hw/rtl/rfd_pkg.sv */
// shared types, constants and checksum function for the rate frame decoder
`timescale 1ns / 1ps

package rfd_pkg;

	localparam int BYTE_W     = 8;
	localparam int GROUP_W    = 7;
	localparam int PACK_W     = 56;
	localparam int POS_W      = 3;
	localparam int RATE_W     = 16;
	localparam int COUNT_W    = 32;
	localparam int OUT_DATA_W = 80;

	localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
	localparam logic [POS_W-1:0] POS_LAST = 3'd7;
	localparam int SYNC_BIT = 7;

	// one input word held in the input register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} rfd_word_t;

	// unpacked byte k of the 56-bit word, byte 0 in the top bits
	function automatic logic [BYTE_W-1:0] unpacked_byte(input logic [PACK_W-1:0] word,
		input int k);
		unpacked_byte = word[PACK_W-1-BYTE_W*k -: BYTE_W];
	endfunction

	// byte 0 must equal the negated 8-bit sum of bytes 1 to 6
	function automatic logic checksum_good(input logic [PACK_W-1:0] word);
		logic [BYTE_W-1:0] sum;
		sum = '0;
		for (int k = 1; k < 7; k++) begin
			sum = sum + unpacked_byte(word, k);
		end
		checksum_good = ((8'd0 - sum) == unpacked_byte(word, 0));
	endfunction

endpackage

/* hw/rtl/sync_packed_rate_frame_decoder_top.sv */
// top level of the sync-packed rate frame decoder
//
//  channel         dir  tdata (low bit up)                            tuser
//  s_axis          in   rx_byte[7:0]                                  -
//  m_axis          out  rate_raw[15:0] frame_count[47:16]             checksum_ok
//                       error_count[79:48]
//
// one byte is taken every cycle unless a closing byte waits on a stalled result;
// a frame gives one result word after its eighth byte, via input and result register
// the frame checksum and counter steps settle in the single stage between the two registers
// reset clears position, packed word, counters and both valid flags
// a stalled result holds only a closing byte back; other bytes keep flowing
`timescale 1ns / 1ps

module sync_packed_rate_frame_decoder_top import rfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // rate_raw, frame_count, error_count
	output logic [0:0]            m_axis_tuser    // checksum_ok
);

	rfd_word_t          word_s1;
	logic               advance;
	logic [RATE_W-1:0]  rate_raw;
	logic               checksum_ok;
	logic [COUNT_W-1:0] frame_count, error_count;

	// input register
	rfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.advance  (advance),
		.word_s1  (word_s1)
	);

	// decoder and result register
	rfd_frame_dec u_frame_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_s1     (word_s1),
		.advance     (advance),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.rate_raw    (rate_raw),
		.checksum_ok (checksum_ok),
		.frame_count (frame_count),
		.error_count (error_count)
	);

	// output packing
	assign m_axis_tdata = {error_count, frame_count, rate_raw};
	assign m_axis_tuser = checksum_ok;

endmodule

/* hw/rtl/rfd_in_reg.sv */
// input register stage of the rate frame decoder
`timescale 1ns / 1ps

module rfd_in_reg import rfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_data,
	input  logic              advance,
	output rfd_word_t         word_s1
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	// take a new word when the stage is empty or moving on
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign word_s1 = '{valid: valid_s1, data: data_s1};

endmodule

/* hw/rtl/rfd_frame_dec.sv */
// frame assembly, checksum, counters and result register
`timescale 1ns / 1ps

module rfd_frame_dec import rfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfd_word_t             word_s1,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RATE_W-1:0]     rate_raw,
	output logic                  checksum_ok,
	output logic [COUNT_W-1:0]    frame_count,
	output logic [COUNT_W-1:0]    error_count
);

	logic [POS_W-1:0]   pos_q, pos_d;
	logic [PACK_W-1:0]  packed_q, packed_d;
	logic [COUNT_W-1:0] frames_seen_q, frames_bad_q;
	logic               hunt, last, load, ok;

	assign hunt = (pos_q == POS_HUNT);
	assign last = !hunt && (pos_q == POS_LAST);

	// a closing word waits only while the result register is full and stalled
	assign advance = word_s1.valid && (!last || !out_valid || out_ready);
	assign load    = advance && last;

	// next position and packed word
	always_comb begin
		pos_d    = pos_q;
		packed_d = packed_q;
		if (hunt) begin
			if (word_s1.data[SYNC_BIT]) begin
				packed_d = {{(PACK_W-GROUP_W){1'b0}}, word_s1.data[GROUP_W-1:0]};
				pos_d    = POS_W'(1);
			end else begin
				pos_d = POS_HUNT;
			end
		end else begin
			packed_d = {packed_q[PACK_W-GROUP_W-1:0], word_s1.data[GROUP_W-1:0]};
			// wraps back to hunting after the eighth byte
			pos_d    = pos_q + POS_W'(1);
		end
	end

	assign ok = checksum_good(packed_d);

	// frame state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= POS_HUNT;
			packed_q      <= '0;
			frames_seen_q <= '0;
			frames_bad_q  <= '0;
		end else if (advance) begin
			pos_q    <= pos_d;
			packed_q <= packed_d;
			if (load) begin
				frames_seen_q <= frames_seen_q + COUNT_W'(1);
				if (!ok) begin
					frames_bad_q <= frames_bad_q + COUNT_W'(1);
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			rate_raw    <= {unpacked_byte(packed_d, 5), unpacked_byte(packed_d, 6)};
			checksum_ok <= ok;
			frame_count <= frames_seen_q + COUNT_W'(1);
			error_count <= ok ? frames_bad_q : frames_bad_q + COUNT_W'(1);
		end
	end

	// a finished frame bumps the frame count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> frames_seen_q == $past(frames_seen_q) + COUNT_W'(1))
		else $error("frame count did not step on a finished frame");

	// a good frame leaves the error count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		load && ok |=> frames_bad_q == $past(frames_bad_q))
		else $error("error count moved on a good frame");

	// a shown result carries the live counts
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_count == frames_seen_q) && (error_count == frames_bad_q))
		else $error("shown counts differ from the counters");

	// no closing word moves while a stalled result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		word_s1.valid && last && out_valid && !out_ready |-> !advance)
		else $error("result overwritten while stalled");

endmodule

/* dv/rate_frame_checker.sv */
// scoreboard for the rate frame decoder: predicts each frame result and compares it on m_axis
`timescale 1ns / 1ps

module rate_frame_checker import rfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // rx_byte
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // rate_raw, frame_count, error_count
	input  logic [0:0]            m_axis_tuser,   // checksum_ok
	output int                    fail_count,
	output int                    pending
);

	localparam int FRAME_LEN = 8;

	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic                     ok;
		logic [COUNT_W-1:0]       frames;
		logic [COUNT_W-1:0]       bad_frames;
	} frame_result_t;

	// predicted decoder state
	logic [3:0]         byte_pos;
	logic [PACK_W-1:0]  gathered;
	logic [COUNT_W-1:0] frame_total;
	logic [COUNT_W-1:0] bad_total;

	frame_result_t expected_frames[$];
	int            fails;

	// fold one accepted word into the predicted state, queue a result on the eighth byte
	task automatic decode_rx_byte(input logic [7:0] rx);
		logic [7:0]    sum;
		frame_result_t r;
		if (byte_pos == 0 || byte_pos >= FRAME_LEN) begin
			if (rx[7]) begin
				gathered = {{(PACK_W-GROUP_W){1'b0}}, rx[6:0]};
				byte_pos = 4'd1;
			end else begin
				byte_pos = 4'd0;
			end
		end else begin
			gathered = {gathered[PACK_W-GROUP_W-1:0], rx[6:0]};
			byte_pos = byte_pos + 4'd1;
			if (byte_pos == FRAME_LEN) begin
				byte_pos = 4'd0;
				sum = '0;
				for (int k = 1; k < 7; k++) begin
					sum = sum + gathered[PACK_W-1-8*k -: 8];
				end
				r.ok = ((8'd0 - sum) == gathered[PACK_W-1 -: 8]);
				r.rate = gathered[15:0];
				frame_total = frame_total + 1;
				if (!r.ok) begin
					bad_total = bad_total + 1;
				end
				r.frames = frame_total;
				r.bad_frames = bad_total;
				expected_frames.push_back(r);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
			fails++;
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			byte_pos = 0;
			gathered = '0;
			frame_total = '0;
			bad_total = '0;
			fails = 0;
			expected_frames.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_rx_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_frames.size() == 0) begin
					$error("result word with no frame pending: tdata 0x%h", m_axis_tdata);
					fails++;
				end else begin
					want = expected_frames.pop_front();
					compare_field("rate_raw", {16'd0, want.rate}, 32'(m_axis_tdata[15:0]));
					compare_field("checksum_ok", 32'(want.ok), 32'(m_axis_tuser[0]));
					compare_field("frame_count", want.frames, m_axis_tdata[47:16]);
					compare_field("error_count", want.bad_frames, m_axis_tdata[79:48]);
				end
			end
			fail_count <= fails;
			pending <= expected_frames.size();
		end
	end

endmodule

/* dv/tb_sync_packed_rate_frame_decoder_top.sv */
// testbench top for the rate frame decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_sync_packed_rate_frame_decoder_top;
	import rfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DATA_TARGET = 950;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // rx_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // rate_raw, frame_count, error_count
	logic [0:0]            m_axis_tuser;   // checksum_ok

	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;
	logic        steady_tx;

	sync_packed_rate_frame_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	rate_frame_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cycle count and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side backpressure, with a window of steady acceptance
	always @(negedge clk) begin
		if (cycle_count >= 600 && cycle_count < 900) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 8);
		end
	end

	// present one word at the falling edge and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!steady_tx && $urandom_range(0, 99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	// body holds unpacked bytes 1 to 6; byte 0 is the negated sum xor chk_flip
	task automatic send_frame(input logic [47:0] body, input logic [7:0] chk_flip,
		input logic [7:0] tail_tops);
		logic [7:0]  sum;
		logic [55:0] word;
		sum = '0;
		for (int k = 0; k < 6; k++) begin
			sum = sum + body[47-8*k -: 8];
		end
		word = {(8'd0 - sum) ^ chk_flip, body};
		for (int i = 0; i < 8; i++) begin
			send_byte({(i == 0) ? 1'b1 : tail_tops[i], word[55-7*i -: 7]});
		end
	endtask

	initial begin
		logic [47:0] body;
		int          data_bytes;
		int          frame_no;
		int          pick;
		int          n;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		steady_tx = 1'b0;
		data_bytes = 0;
		frame_no = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: dropped noise while hunting, rate extremes, bad checksum, top bits in frame
		send_byte(8'h00);
		send_byte(8'h7f);
		send_frame(48'h0123_4567_8000, 8'h00, 8'haa);
		send_frame(48'hffff_ffff_ffff, 8'hf9, 8'hff);
		send_frame(48'h8000_0000_7fff, 8'h00, 8'h00);

		// random: mostly whole frames, some noise and cut-short frames
		while (data_bytes < DATA_TARGET) begin
			steady_tx = (frame_no >= 30 && frame_no < 50);
			pick = $urandom_range(0, 99);
			body[47:32] = 16'($urandom);
			body[31:0] = $urandom;
			case ($urandom_range(0, 7))
				0: body[15:0] = 16'h7fff;
				1: body[15:0] = 16'h8000;
				2: body[15:0] = 16'h0000;
				3: body[15:0] = 16'hffff;
				default: ;
			endcase
			if (pick < 60) begin
				send_frame(body, 8'h00, 8'($urandom));
				data_bytes += 8;
			end else if (pick < 80) begin
				send_frame(body, 8'($urandom_range(1, 255)), 8'($urandom));
				data_bytes += 8;
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) send_byte({1'b0, 7'($urandom)});
			end else begin
				n = $urandom_range(1, 7);
				send_byte({1'b1, 7'($urandom)});
				repeat (n - 1) send_byte(8'($urandom));
				data_bytes += n;
			end
			frame_no++;
		end
		steady_tx = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain, then keep watching to catch stray result words
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			if (pending != 0) begin
				$error("%0d frame results never arrived", pending);
			end
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_in_reg.sv
hw/rtl/rfd_frame_dec.sv
hw/rtl/sync_packed_rate_frame_decoder_top.sv
dv/rate_frame_checker.sv
dv/tb_sync_packed_rate_frame_decoder_top.sv
